[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Synthesis builds define SYNTH and get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[hw/rtl/dmc_pkg.sv]
`default_nettype none
package dmc_pkg;

   localparam int GRID_W = 6;

   localparam logic [GRID_W-1:0] GRID_DIM_RESET = 6'd10;
   localparam logic [3:0]        WALLS_CLOSED   = 4'hF;

   // Operation codes of a request.
   localparam logic [1:0] OP_RESTART = 2'd0;
   localparam logic [1:0] OP_STEP    = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;
   localparam logic [1:0] OP_NONE    = 2'd3;

   // Result kinds.
   localparam logic [2:0] KIND_RESTARTED  = 3'd0;
   localparam logic [2:0] KIND_CARVED     = 3'd1;
   localparam logic [2:0] KIND_BACKTRACK  = 3'd2;
   localparam logic [2:0] KIND_FINISHED   = 3'd3;
   localparam logic [2:0] KIND_WALL_READ  = 3'd4;

   // Directions, also the wall bit positions.
   localparam logic [1:0] DIR_RT = 2'd0;
   localparam logic [1:0] DIR_DN = 2'd1;
   localparam logic [1:0] DIR_LT = 2'd2;
   localparam logic [1:0] DIR_UP = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [4:0] perm_index;
      logic [4:0] cell_x;
      logic [4:0] cell_y;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [4:0]  from_x;
      logic [4:0]  from_y;
      logic [4:0]  to_x;
      logic [4:0]  to_y;
      logic [3:0]  wall_bits;
      logic [10:0] stack_depth;
   } rsp_type;

   typedef struct packed {
      logic       visited;
      logic [3:0] walls;
   } cell_entry_type;

   typedef struct packed {
      logic go;
      logic mark;
   } clr_ctrl_type;

   // Element k is the k-th direction to try.
   typedef logic [3:0][1:0] perm_type;

   function automatic perm_type mk_order(input logic [1:0] a, input logic [1:0] b,
                                         input logic [1:0] c, input logic [1:0] d);
      perm_type r;
      r[0] = a;
      r[1] = b;
      r[2] = c;
      r[3] = d;
      return r;
   endfunction

   // Lexicographic permutation of the four directions; indexes above 23 act as 23.
   function automatic perm_type perm_order(input logic [4:0] idx);
      perm_type r;
      unique case (idx)
         5'd0: r = mk_order(DIR_RT, DIR_DN, DIR_LT, DIR_UP);
         5'd1: r = mk_order(DIR_RT, DIR_DN, DIR_UP, DIR_LT);
         5'd2: r = mk_order(DIR_RT, DIR_LT, DIR_DN, DIR_UP);
         5'd3: r = mk_order(DIR_RT, DIR_LT, DIR_UP, DIR_DN);
         5'd4: r = mk_order(DIR_RT, DIR_UP, DIR_DN, DIR_LT);
         5'd5: r = mk_order(DIR_RT, DIR_UP, DIR_LT, DIR_DN);
         5'd6: r = mk_order(DIR_DN, DIR_RT, DIR_LT, DIR_UP);
         5'd7: r = mk_order(DIR_DN, DIR_RT, DIR_UP, DIR_LT);
         5'd8: r = mk_order(DIR_DN, DIR_LT, DIR_RT, DIR_UP);
         5'd9: r = mk_order(DIR_DN, DIR_LT, DIR_UP, DIR_RT);
         5'd10: r = mk_order(DIR_DN, DIR_UP, DIR_RT, DIR_LT);
         5'd11: r = mk_order(DIR_DN, DIR_UP, DIR_LT, DIR_RT);
         5'd12: r = mk_order(DIR_LT, DIR_RT, DIR_DN, DIR_UP);
         5'd13: r = mk_order(DIR_LT, DIR_RT, DIR_UP, DIR_DN);
         5'd14: r = mk_order(DIR_LT, DIR_DN, DIR_RT, DIR_UP);
         5'd15: r = mk_order(DIR_LT, DIR_DN, DIR_UP, DIR_RT);
         5'd16: r = mk_order(DIR_LT, DIR_UP, DIR_RT, DIR_DN);
         5'd17: r = mk_order(DIR_LT, DIR_UP, DIR_DN, DIR_RT);
         5'd18: r = mk_order(DIR_UP, DIR_RT, DIR_DN, DIR_LT);
         5'd19: r = mk_order(DIR_UP, DIR_RT, DIR_LT, DIR_DN);
         5'd20: r = mk_order(DIR_UP, DIR_DN, DIR_RT, DIR_LT);
         5'd21: r = mk_order(DIR_UP, DIR_DN, DIR_LT, DIR_RT);
         5'd22: r = mk_order(DIR_UP, DIR_LT, DIR_RT, DIR_DN);
         default: r = mk_order(DIR_UP, DIR_LT, DIR_DN, DIR_RT);
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/dmc_cell_store.sv]
`default_nettype none
`include "assert_macros.svh"
module dmc_cell_store #(
   parameter int AW = 10
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire dmc_pkg::clr_ctrl_type   clr_ctrl,
   output logic                         clr_done,
   input  wire logic [AW-1:0]           rd_addr,
   output dmc_pkg::cell_entry_type      rd_data,
   input  wire logic                    wr_en,
   input  wire logic [AW-1:0]           wr_addr,
   input  wire dmc_pkg::cell_entry_type wr_data
);

   dmc_pkg::cell_entry_type cell_mem [2**AW];
   dmc_pkg::cell_entry_type rd_data_ff;

   logic          clearing_ff, clearing_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          mark_ff, mark_in;

   logic                    mem_we;
   logic [AW-1:0]           mem_addr;
   dmc_pkg::cell_entry_type mem_data;

   assign clr_done = clearing_ff && (&clr_addr_ff);
   assign rd_data  = rd_data_ff;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      mark_in     = mark_ff;
      if (clr_ctrl.go) begin
         clearing_in = 1'b1;
         clr_addr_in = '0;
         mark_in     = clr_ctrl.mark;
      end else if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (&clr_addr_ff) begin
            clearing_in = 1'b0;
         end
      end
   end

   // The sweep owns the write port; a restart marks the origin cell visited on the way.
   always_comb begin
      mem_we   = clearing_ff || wr_en;
      mem_addr = clearing_ff ? clr_addr_ff : wr_addr;
      if (clearing_ff) begin
         mem_data.visited = mark_ff && (clr_addr_ff == '0);
         mem_data.walls   = dmc_pkg::WALLS_CLOSED;
      end else begin
         mem_data = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
         mark_ff     <= 1'b0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
         mark_ff     <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_addr] <= mem_data;
      end
      rd_data_ff <= cell_mem[rd_addr];
   end

   `ASSERT_ALWAYS(a_no_write_in_sweep, clock, reset, !(clearing_ff && wr_en), "write during clear")
   `ASSERT_IMPLY(a_go_when_idle, clock, reset, clr_ctrl.go, !clearing_ff, "clear restarted early")

endmodule
`default_nettype wire

[hw/rtl/dfs_maze_carver.sv]
// Maze carver: a request is taken on a clock edge with start high and busy low, and unless its
// op is OP_NONE its one result appears on rsp_item for exactly one cycle with rsp_strobe high;
// the receiver cannot stall it, so it must take every strobe. A step on an empty stack answers
// in the next cycle and never raises busy. A wall read is answered from ST_READ. A step that
// carves or backtracks keeps busy high through ST_TOP and ST_SCAN (a carve also through ST_CARVE
// and ST_LINK), since the cell memory has one read port and the top cell and each candidate
// neighbour are read one per cycle in the chosen order. Reset and every restart sweep the whole
// cell memory with busy high; the restart result follows the sweep. csr_wr_data may only
// be written while busy is low and no result is pending.
`default_nettype none
`include "assert_macros.svh"
module dfs_maze_carver #(
   parameter int MAX_DIM = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire dmc_pkg::req_type            req_item,
   output logic                             rsp_strobe,
   output dmc_pkg::rsp_type                 rsp_item,
   input  wire logic                        csr_wr_en,
   input  wire logic [dmc_pkg::GRID_W-1:0]  csr_wr_data
);

   localparam int CW    = $clog2(MAX_DIM);
   localparam int AW    = 2 * CW;
   localparam int CELLS = MAX_DIM * MAX_DIM;
   localparam int SW    = $clog2(CELLS);
   localparam int SPW   = $clog2(CELLS + 1);
   localparam int DW    = (CW >= dmc_pkg::GRID_W) ? CW + 1 : dmc_pkg::GRID_W + 1;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_TOP   = 7'b0000100,
      ST_SCAN  = 7'b0001000,
      ST_CARVE = 7'b0010000,
      ST_LINK  = 7'b0100000,
      ST_READ  = 7'b1000000
   } state_type;

   state_type                   state_ff, state_in;
   logic [SPW-1:0]              sp_ff, sp_in;
   logic [dmc_pkg::GRID_W-1:0]  grid_dim_ff, grid_dim_in;
   dmc_pkg::perm_type           order_ff, order_in;
   logic [AW-1:0]               top_ff, top_in;
   dmc_pkg::cell_entry_type     top_ent_ff, top_ent_in;
   logic [2:0]                  pos_ff, pos_in;
   logic [1:0]                  dir_ff, dir_in;
   logic [AW-1:0]               nbr_ff, nbr_in;
   dmc_pkg::cell_entry_type     nbr_ent_ff, nbr_ent_in;
   logic                        in_store_ff, in_store_in;
   logic                        restart_ff, restart_in;
   logic                        rsp_strobe_ff, rsp_strobe_in;
   dmc_pkg::rsp_type            rsp_ff, rsp_in;

   logic [AW-1:0] stack_mem [CELLS];
   logic [AW-1:0] stack_rd_ff;
   logic          stk_we;
   logic [SW-1:0] stk_waddr;
   logic [AW-1:0] stk_wdata;
   logic [SW-1:0] stk_raddr;
   logic [SPW-1:0] sp_m1;

   dmc_pkg::clr_ctrl_type   clr_ctrl;
   logic                    clr_done;
   logic [AW-1:0]           cell_raddr;
   dmc_pkg::cell_entry_type cell_rd;
   logic                    cell_we;
   logic [AW-1:0]           cell_waddr;
   dmc_pkg::cell_entry_type cell_wdata;

   logic [DW-1:0] grid_ext, dim;
   logic [DW-1:0] rd_x_ext, rd_y_ext;
   logic [1:0]    pos_m1;
   logic [AW:0]   iss_nbr, chk_nbr;
   logic          full, hit;
   logic [1:0]    opp_dir;

   // Neighbour of a cell in one direction, with an in-grid flag on top.
   function automatic logic [AW:0] step_to(input logic [AW-1:0] cur, input logic [1:0] dir,
                                           input logic [DW-1:0] lim);
      logic [CW:0] nx;
      logic [CW:0] ny;
      logic        inb;
      nx  = {1'b0, cur[CW-1:0]};
      ny  = {1'b0, cur[AW-1:CW]};
      inb = 1'b1;
      case (dir)
         dmc_pkg::DIR_RT: nx = nx + 1'b1;
         dmc_pkg::DIR_DN: ny = ny + 1'b1;
         dmc_pkg::DIR_LT: begin
            if (nx == '0) inb = 1'b0;
            else nx = nx - 1'b1;
         end
         dmc_pkg::DIR_UP: begin
            if (ny == '0) inb = 1'b0;
            else ny = ny - 1'b1;
         end
         default: inb = 1'b0;
      endcase
      inb = inb && (DW'(nx) < lim) && (DW'(ny) < lim);
      return {inb, ny[CW-1:0], nx[CW-1:0]};
   endfunction

   dmc_cell_store #(
      .AW (AW)
   ) u_cell_store (
      .clock    (clock),
      .reset    (reset),
      .clr_ctrl (clr_ctrl),
      .clr_done (clr_done),
      .rd_addr  (cell_raddr),
      .rd_data  (cell_rd),
      .wr_en    (cell_we),
      .wr_addr  (cell_waddr),
      .wr_data  (cell_wdata)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   assign grid_ext = DW'(grid_dim_ff);
   assign dim      = (grid_ext < DW'(2)) ? DW'(2) :
                     (grid_ext > DW'(MAX_DIM)) ? DW'(MAX_DIM) : grid_ext;
   assign rd_x_ext = DW'(req_item.cell_x);
   assign rd_y_ext = DW'(req_item.cell_y);

   assign sp_m1     = sp_ff - 1'b1;
   assign stk_raddr = (sp_ff == '0) ? '0 : sp_m1[SW-1:0];
   assign full      = (sp_ff >= SPW'(CELLS));

   assign pos_m1  = 2'(pos_ff - 3'd1);
   assign iss_nbr = step_to(top_ff, order_ff[pos_ff[1:0]], dim);
   assign chk_nbr = step_to(top_ff, order_ff[pos_m1], dim);
   assign hit     = (pos_ff != 3'd0) && chk_nbr[AW] && !cell_rd.visited && !full;
   assign opp_dir = 2'(dir_ff + 2'd2);

   always_comb begin
      state_in      = state_ff;
      sp_in         = sp_ff;
      grid_dim_in   = csr_wr_en ? csr_wr_data : grid_dim_ff;
      order_in      = order_ff;
      top_in        = top_ff;
      top_ent_in    = top_ent_ff;
      pos_in        = pos_ff;
      dir_in        = dir_ff;
      nbr_in        = nbr_ff;
      nbr_ent_in    = nbr_ent_ff;
      in_store_in   = in_store_ff;
      restart_in    = restart_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      clr_ctrl      = '0;
      cell_raddr    = '0;
      cell_we       = 1'b0;
      cell_waddr    = top_ff;
      cell_wdata    = top_ent_ff;
      stk_we        = 1'b0;
      stk_waddr     = sp_ff[SW-1:0];
      stk_wdata     = nbr_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_done) begin
               state_in   = ST_IDLE;
               restart_in = 1'b0;
               if (restart_ff) begin
                  sp_in                = SPW'(1);
                  rsp_strobe_in        = 1'b1;
                  rsp_in.kind          = dmc_pkg::KIND_RESTARTED;
                  rsp_in.stack_depth   = 11'd1;
               end
            end
         end
         ST_IDLE: begin
            cell_raddr = {rd_y_ext[CW-1:0], rd_x_ext[CW-1:0]};
            if (start) begin
               unique case (req_item.op)
                  dmc_pkg::OP_RESTART: begin
                     clr_ctrl.go   = 1'b1;
                     clr_ctrl.mark = 1'b1;
                     restart_in    = 1'b1;
                     stk_we        = 1'b1;
                     stk_waddr     = '0;
                     stk_wdata     = '0;
                     state_in      = ST_CLEAR;
                  end
                  dmc_pkg::OP_STEP: begin
                     order_in = dmc_pkg::perm_order(req_item.perm_index);
                     if (sp_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.kind   = dmc_pkg::KIND_FINISHED;
                     end else begin
                        state_in = ST_TOP;
                     end
                  end
                  dmc_pkg::OP_READ: begin
                     in_store_in = (rd_x_ext < DW'(MAX_DIM)) && (rd_y_ext < DW'(MAX_DIM));
                     state_in    = ST_READ;
                  end
                  dmc_pkg::OP_NONE: begin
                     state_in = ST_IDLE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_TOP: begin
            top_in     = stack_rd_ff;
            cell_raddr = stack_rd_ff;
            pos_in     = 3'd0;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            // Read data arriving now belongs to the address issued in the previous cycle.
            cell_raddr = iss_nbr[AW-1:0];
            if (pos_ff == 3'd0) begin
               top_ent_in = cell_rd;
               pos_in     = 3'd1;
            end else if (hit) begin
               dir_in     = order_ff[pos_m1];
               nbr_in     = chk_nbr[AW-1:0];
               nbr_ent_in = cell_rd;
               state_in   = ST_CARVE;
            end else if (pos_ff == 3'd4) begin
               sp_in              = sp_m1;
               rsp_strobe_in      = 1'b1;
               rsp_in.kind        = dmc_pkg::KIND_BACKTRACK;
               rsp_in.from_x      = 5'(top_ff[CW-1:0]);
               rsp_in.from_y      = 5'(top_ff[AW-1:CW]);
               rsp_in.stack_depth = 11'(sp_m1);
               state_in           = ST_IDLE;
            end else begin
               pos_in = pos_ff + 3'd1;
            end
         end
         ST_CARVE: begin
            cell_we                = 1'b1;
            cell_waddr             = top_ff;
            cell_wdata.visited     = top_ent_ff.visited;
            cell_wdata.walls       = top_ent_ff.walls & ~(4'b0001 << dir_ff);
            stk_we                 = 1'b1;
            sp_in                  = sp_ff + 1'b1;
            rsp_strobe_in          = 1'b1;
            rsp_in.kind            = dmc_pkg::KIND_CARVED;
            rsp_in.from_x          = 5'(top_ff[CW-1:0]);
            rsp_in.from_y          = 5'(top_ff[AW-1:CW]);
            rsp_in.to_x            = 5'(nbr_ff[CW-1:0]);
            rsp_in.to_y            = 5'(nbr_ff[AW-1:CW]);
            rsp_in.stack_depth     = 11'(sp_in);
            state_in               = ST_LINK;
         end
         ST_LINK: begin
            cell_we            = 1'b1;
            cell_waddr         = nbr_ff;
            cell_wdata.visited = 1'b1;
            cell_wdata.walls   = nbr_ent_ff.walls & ~(4'b0001 << opp_dir);
            state_in           = ST_IDLE;
         end
         ST_READ: begin
            rsp_strobe_in      = 1'b1;
            rsp_in.kind        = dmc_pkg::KIND_WALL_READ;
            rsp_in.wall_bits   = in_store_ff ? cell_rd.walls : dmc_pkg::WALLS_CLOSED;
            rsp_in.stack_depth = 11'(sp_ff);
            if (sp_ff != '0) begin
               rsp_in.from_x = 5'(stack_rd_ff[CW-1:0]);
               rsp_in.from_y = 5'(stack_rd_ff[AW-1:CW]);
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         sp_ff         <= '0;
         grid_dim_ff   <= dmc_pkg::GRID_DIM_RESET;
         restart_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sp_ff         <= sp_in;
         grid_dim_ff   <= grid_dim_in;
         restart_ff    <= restart_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      order_ff    <= order_in;
      top_ff      <= top_in;
      top_ent_ff  <= top_ent_in;
      pos_ff      <= pos_in;
      dir_ff      <= dir_in;
      nbr_ff      <= nbr_in;
      nbr_ent_ff  <= nbr_ent_in;
      in_store_ff <= in_store_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      stack_rd_ff <= stack_mem[stk_raddr];
   end

   `ASSERT_ALWAYS(a_sp_bound, clock, reset, sp_ff <= SPW'(CELLS), "stack pointer overrun")
   `ASSERT_IMPLY(a_carve_depth, clock, reset, rsp_strobe_ff && (rsp_ff.kind == dmc_pkg::KIND_CARVED), sp_ff >= SPW'(2), "carve with short stack")
   `ASSERT_IMPLY(a_finish_empty, clock, reset, rsp_strobe_ff && (rsp_ff.kind == dmc_pkg::KIND_FINISHED), sp_ff == '0, "finished with cells on stack")
   `ASSERT_IMPLY(a_link_distinct, clock, reset, state_ff == ST_LINK, nbr_ff != top_ff, "carved cell equals top cell")
   `ASSERT_NEXT(a_carve_then_link, clock, reset, state_ff == ST_CARVE, !rsp_strobe_in && busy, "second result for one step")

endmodule
`default_nettype wire
